// ===== rtl/tpd_pkg.sv =====
package tpd_pkg;

    typedef enum logic [1:0] {
        PH_HEAD     = 2'd0,
        PH_PAY      = 2'd1,
        PH_ERR      = 2'd2,
        PH_HEAD_BAD = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_SHORT   = 2'd1,
        ERR_BAD_HDR = 2'd2,
        ERR_LENGTH  = 2'd3
    } t_err;

    typedef struct packed {
        logic        emit;
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        t_err        code;
    } t_parse_res;

    localparam logic [7:0]  HDR_B0          = 8'h53;
    localparam logic [7:0]  HDR_B1          = 8'h54;
    localparam logic [7:0]  HDR_B2          = 8'h46;
    localparam logic [7:0]  HDR_B3          = 8'h01;
    localparam logic [2:0]  HDR_LAST_POS    = 3'd7;
    localparam logic [7:0]  TYPE_DATA       = 8'd0;
    localparam logic [7:0]  TYPE_DPD_REQ    = 8'd3;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd2040;
    localparam logic [2:0]  REPLY_LAST_IDX  = 3'd7;

    function automatic logic [7:0] reply_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h53;
            3'd1:    b = 8'h54;
            3'd2:    b = 8'h46;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h00;
            3'd6:    b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/tunnel_packet_deframer.sv =====
// A result appears on the output register in the cycle after its item is accepted.
// Throughput: one byte per cycle while o_stall is low; the header parser and output register run every cycle.
// A dead-peer-detection reply is eight output bytes; o_stall holds input off
// while the first seven of them are shown.
// Reset (synchronous, active low): parser to header phase, output empty,
// max_payload back to 2040.
module tunnel_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_record_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [1:0]  o_error_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import tpd_pkg::*;

    logic [15:0] r_max_payload;
    logic        r_out_valid, n_out_valid;
    t_kind       r_out_kind, n_out_kind;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;
    t_err        r_out_code, n_out_code;
    logic [2:0]  r_idx, n_idx;
    logic        out_free;
    logic        burst_busy;
    logic        accept;
    t_parse_res  res;

    assign out_free   = !r_out_valid || !i_stall;
    assign burst_busy = r_out_valid && (r_out_kind == KIND_REPLY) && !r_out_last;
    assign o_stall    = !out_free || burst_busy;
    assign accept     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    tpd_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_record_end  (i_record_end),
        .i_max_payload (r_max_payload),
        .o_res         (res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_code  = r_out_code;
        n_idx       = r_idx;
        if (out_free) begin
            if (burst_busy) begin
                n_idx       = r_idx + 3'd1;
                n_out_valid = 1'b1;
                n_out_byte  = reply_byte(n_idx);
                n_out_last  = (n_idx == REPLY_LAST_IDX);
            end else if (res.emit) begin
                n_out_valid = 1'b1;
                n_out_kind  = res.kind;
                n_out_byte  = res.data;
                n_out_last  = res.last;
                n_out_code  = res.code;
                n_idx       = 3'd0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_payload <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_code <= n_out_code;
        r_idx      <= n_idx;
    end

    assign o_valid      = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_error_code = r_out_code;

endmodule

// ===== rtl/tpd_parse.sv =====
module tpd_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_record_end,
    input  logic [15:0]           i_max_payload,
    output tpd_pkg::t_parse_res   o_res
);
    import tpd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic        hbad;
    logic        last_byte;
    t_parse_res  res;

    assign last_byte = ({1'b0, r_pos} + 17'd1) >= {1'b0, r_len};

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_len     = r_len;
        n_type    = r_type;
        hbad      = (r_phase == PH_HEAD_BAD);
        res.emit  = 1'b0;
        res.kind  = KIND_PAYLOAD;
        res.data  = i_rx_byte;
        res.last  = 1'b0;
        res.code  = ERR_NONE;
        if (i_accept) begin
            case (r_phase)
                PH_HEAD, PH_HEAD_BAD: begin
                    case (r_pos[2:0])
                        3'd0:    hbad = hbad || (i_rx_byte != HDR_B0);
                        3'd1:    hbad = hbad || (i_rx_byte != HDR_B1);
                        3'd2:    hbad = hbad || (i_rx_byte != HDR_B2);
                        3'd3:    hbad = hbad || (i_rx_byte != HDR_B3);
                        3'd4:    n_len = {i_rx_byte, 8'h00};
                        3'd5:    n_len = {r_len[15:8], i_rx_byte};
                        3'd6:    n_type = i_rx_byte;
                        default: hbad = hbad || (i_rx_byte != 8'h00);
                    endcase
                    if (r_pos[2:0] != HDR_LAST_POS) begin
                        if (i_record_end) begin
                            res.emit = 1'b1;
                            res.code = ERR_SHORT;
                        end else begin
                            n_phase = hbad ? PH_HEAD_BAD : PH_HEAD;
                            n_pos   = r_pos + 16'd1;
                        end
                    end else if (hbad) begin
                        res.emit = 1'b1;
                        res.code = ERR_BAD_HDR;
                    end else if (r_len > i_max_payload) begin
                        res.emit = 1'b1;
                        res.code = ERR_LENGTH;
                    end else if (r_len == 16'd0) begin
                        if (!i_record_end) begin
                            res.emit = 1'b1;
                            res.code = ERR_LENGTH;
                        end else begin
                            n_phase = PH_HEAD;
                            n_pos   = 16'd0;
                            if (r_type == TYPE_DPD_REQ) begin
                                res.emit = 1'b1;
                                res.kind = KIND_REPLY;
                                res.data = reply_byte(3'd0);
                            end
                        end
                    end else if (i_record_end) begin
                        res.emit = 1'b1;
                        res.code = ERR_LENGTH;
                    end else begin
                        n_phase = PH_PAY;
                        n_pos   = 16'd0;
                    end
                end
                PH_PAY: begin
                    if (last_byte != i_record_end) begin
                        res.emit = 1'b1;
                        res.code = ERR_LENGTH;
                    end else if (!last_byte) begin
                        n_pos = r_pos + 16'd1;
                        if (r_type == TYPE_DATA) begin
                            res.emit = 1'b1;
                        end
                    end else begin
                        n_phase = PH_HEAD;
                        n_pos   = 16'd0;
                        if (r_type == TYPE_DATA) begin
                            res.emit = 1'b1;
                            res.last = 1'b1;
                        end else if (r_type == TYPE_DPD_REQ) begin
                            res.emit = 1'b1;
                            res.kind = KIND_REPLY;
                            res.data = reply_byte(3'd0);
                        end
                    end
                end
                default: begin
                end
            endcase
            // any error halts the parser
            if (res.code != ERR_NONE) begin
                res.kind = KIND_ERROR;
                res.data = 8'h00;
                res.last = 1'b1;
                n_phase  = PH_ERR;
                n_pos    = 16'd0;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_pos   <= 16'd0;
            r_len   <= 16'd0;
            r_type  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_type  <= n_type;
        end
    end

endmodule

// ===== rtl/tpd_checker.sv =====
module tpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_out_kind,
    input logic [7:0]  o_out_byte,
    input logic        o_out_last,
    input logic [1:0]  o_error_code
);
    import tpd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_out_kind))
        else $error("stalled result changed");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_ERROR) |->
            o_out_last && (o_out_byte == 8'h00) && (o_error_code != ERR_NONE))
        else $error("malformed error report");

    a_err_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_out_kind == KIND_ERROR) |=> !o_valid)
        else $error("output after error report");

    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_REPLY) && !o_out_last |-> o_stall)
        else $error("input taken during reply burst");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind != KIND_ERROR) |-> (o_error_code == ERR_NONE))
        else $error("error code on data item");

endmodule

bind tunnel_packet_deframer tpd_checker u_tpd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_kind   (o_out_kind),
    .o_out_byte   (o_out_byte),
    .o_out_last   (o_out_last),
    .o_error_code (o_error_code)
);
